/* hw/rtl/e2g_pkg.sv */
`timescale 1ns / 1ps

package e2g_pkg;

  localparam int unsigned OpW = 5;
  typedef logic [OpW-1:0] op_t;

  // datapath operations
  localparam op_t OP_ZOUT = 5'd0;
  localparam op_t OP_E2   = 5'd1;
  localparam op_t OP_RX   = 5'd2;
  localparam op_t OP_RY   = 5'd3;
  localparam op_t OP_DZ0  = 5'd4;
  localparam op_t OP_ZZ   = 5'd5;
  localparam op_t OP_AZ2  = 5'd6;
  localparam op_t OP_NH   = 5'd7;
  localparam op_t OP_SN   = 5'd8;
  localparam op_t OP_S2   = 5'd9;
  localparam op_t OP_DEN  = 5'd10;
  localparam op_t OP_Q    = 5'd11;
  localparam op_t OP_NRAD = 5'd12;
  localparam op_t OP_D1   = 5'd13;
  localparam op_t OP_D2   = 5'd14;
  localparam op_t OP_CHK  = 5'd15;
  localparam op_t OP_RHO  = 5'd16;
  localparam op_t OP_LON  = 5'd17;
  localparam op_t OP_LAT  = 5'd18;
  localparam op_t OP_HGT  = 5'd19;

  typedef struct packed {
    logic start;
    logic load;
    logic emit;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic zero;
    logic conv;
  } stat_t;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_FLAT   = 2'd1;
  localparam logic [1:0] REG_TOL    = 2'd2;

  localparam logic [32:0] RADIUS_RST = 33'd6378137000;
  localparam logic [36:0] FLAT_RST   = 37'd3686454311;
  localparam logic [15:0] TOL_RST    = 16'd16;

  localparam logic [63:0] Q40_ONE = 64'h0000_0100_0000_0000;

  localparam logic signed [34:0] ANG_PI      = 35'sd3373259426;
  localparam logic signed [34:0] ANG_HALF_PI = 35'sd1686629713;

  // arctangent of 2^-i in radians times 2^30
  function automatic logic [29:0] atan_tab(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837830;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/e2g_mul.sv */
`timescale 1ns / 1ps

// 64x64 unsigned multiply, one 32x32 partial product per cycle
module e2g_mul (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [63:0]  a_i,
  input  logic [63:0]  b_i,
  output logic         done_o,
  output logic [127:0] prod_o
);

  logic [63:0]  a_q, b_q, pp_q, pp_d;
  logic [1:0]   sh_q;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [127:0] acc_q;
  logic [31:0]  a_part, b_part;

  assign a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];
  assign pp_d   = a_part * b_part;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 3'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 3'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      pp_q <= pp_d;
      sh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + ({64'd0, pp_q} << {sh_q, 5'd0});
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* hw/rtl/e2g_sqdiv.sv */
`timescale 1ns / 1ps

// shared shift-subtract unit: floor sqrt of 128 bits or 128/64 floor divide, all ones on overflow or zero divisor
module e2g_sqdiv (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic         sqrt_i,
  input  logic [127:0] n_i,
  input  logic [63:0]  d_i,
  output logic         done_o,
  output logic [63:0]  res_o
);

  logic         busy_q, done_q, mode_q, sat_q;
  logic [5:0]   cnt_q;
  logic [65:0]  rem_q;
  logic [127:0] sh_q;
  logic [63:0]  d_q, res_q;
  logic [67:0]  r2s, trial;
  logic [64:0]  r2d, dext;
  logic         ge_s, ge_d;

  assign r2s   = {rem_q, sh_q[127:126]};
  assign trial = {2'b00, res_q, 2'b01};
  assign ge_s  = r2s >= trial;
  assign r2d   = {rem_q[63:0], sh_q[127]};
  assign dext  = {1'b0, d_q};
  assign ge_d  = r2d >= dext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 6'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mode_q <= sqrt_i;
      d_q    <= d_i;
      res_q  <= '0;
      if (sqrt_i) begin
        rem_q <= '0;
        sh_q  <= n_i;
        sat_q <= 1'b0;
      end else begin
        rem_q <= {2'b00, n_i[127:64]};
        sh_q  <= {n_i[63:0], 64'd0};
        sat_q <= (d_i == 64'd0) || (n_i[127:64] >= d_i);
      end
    end else if (busy_q) begin
      if (mode_q) begin
        rem_q <= ge_s ? 66'(r2s - trial) : r2s[65:0];
        sh_q  <= {sh_q[125:0], 2'b00};
        res_q <= {res_q[62:0], ge_s};
      end else begin
        rem_q <= {2'b00, ge_d ? 64'(r2d - dext) : r2d[63:0]};
        sh_q  <= {sh_q[126:0], 1'b0};
        res_q <= {res_q[62:0], ge_d};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q | {64{sat_q}};

endmodule

/* hw/rtl/e2g_cordic.sv */
`timescale 1ns / 1ps

// atan2 by vectoring cordic, one rotation per cycle
module e2g_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] y_i,
  input  logic signed [63:0] x_i,
  output logic               done_o,
  output logic signed [32:0] ang_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NORM = 2'd1;
  localparam logic [1:0] PH_ITER = 2'd2;
  localparam logic [1:0] PH_FIN  = 2'd3;

  localparam logic signed [32:0] ANG_PI_33   = e2g_pkg::ANG_PI[32:0];
  localparam logic signed [32:0] ANG_HALF_33 = e2g_pkg::ANG_HALF_PI[32:0];

  logic [1:0]         ph_q;
  logic [4:0]         it_q;
  logic               done_q;
  logic signed [63:0] xv_q, yv_q, dx, dy;
  logic signed [31:0] z_q, tab;
  logic signed [34:0] base_q, r;
  logic signed [32:0] ang_q;
  logic [63:0]        mx, my, m, m_q;

  // the magnitude is tracked on its own, halved and doubled with the operands
  assign mx  = x_i[63] ? 64'(-x_i) : 64'(x_i);
  assign my  = y_i[63] ? 64'(-y_i) : 64'(y_i);
  assign m   = (mx > my) ? mx : my;
  assign dx  = yv_q >>> it_q;
  assign dy  = xv_q >>> it_q;
  assign tab = $signed({2'b00, e2g_pkg::atan_tab(it_q)});
  assign r   = base_q + 35'(z_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_IDLE;
      it_q   <= 5'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (ph_q)
        PH_IDLE: begin
          if (start_i) begin
            if (y_i == 64'sd0 || x_i == 64'sd0) begin
              done_q <= 1'b1;
            end else begin
              ph_q <= PH_NORM;
            end
          end
        end
        PH_NORM: begin
          if (m_q[63:51] == 13'd0 && m_q[50] == 1'b1) begin
            ph_q <= PH_ITER;
            it_q <= 5'd0;
          end
        end
        PH_ITER: begin
          it_q <= it_q + 5'd1;
          if (it_q == 5'd30) begin
            ph_q <= PH_FIN;
          end
        end
        PH_FIN: begin
          ph_q   <= PH_IDLE;
          done_q <= 1'b1;
        end
        default: ph_q <= PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ph_q)
      PH_IDLE: begin
        if (start_i) begin
          // axis points resolve at once
          if (y_i == 64'sd0) begin
            ang_q <= x_i[63] ? ANG_PI_33 : 33'sd0;
          end else if (x_i == 64'sd0) begin
            ang_q <= y_i[63] ? -ANG_HALF_33 : ANG_HALF_33;
          end
          z_q <= 32'sd0;
          m_q <= m;
          if (x_i[63]) begin
            base_q <= y_i[63] ? -e2g_pkg::ANG_PI : e2g_pkg::ANG_PI;
            xv_q   <= -x_i;
            yv_q   <= -y_i;
          end else begin
            base_q <= 35'sd0;
            xv_q   <= x_i;
            yv_q   <= y_i;
          end
        end
      end
      PH_NORM: begin
        if (m_q[63:51] != 13'd0) begin
          xv_q <= xv_q >>> 1;
          yv_q <= yv_q >>> 1;
          m_q  <= m_q >> 1;
        end else if (m_q[50] == 1'b0) begin
          xv_q <= xv_q <<< 1;
          yv_q <= yv_q <<< 1;
          m_q  <= m_q << 1;
        end
      end
      PH_ITER: begin
        if (yv_q > 64'sd0) begin
          xv_q <= xv_q + dx;
          yv_q <= yv_q - dy;
          z_q  <= z_q + tab;
        end else begin
          xv_q <= xv_q - dx;
          yv_q <= yv_q + dy;
          z_q  <= z_q - tab;
        end
      end
      PH_FIN: begin
        if (r > e2g_pkg::ANG_PI) begin
          ang_q <= ANG_PI_33;
        end else if (r < -e2g_pkg::ANG_PI) begin
          ang_q <= -ANG_PI_33;
        end else begin
          ang_q <= r[32:0];
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign ang_o  = ang_q;

endmodule

/* hw/rtl/e2g_dp.sv */
`timescale 1ns / 1ps

// datapath: working registers, multiplier, root/divide unit and cordic
module e2g_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  e2g_pkg::cmd_t       cmd_i,
  output e2g_pkg::stat_t      stat_o,
  input  logic signed [35:0]  x_i,
  input  logic signed [35:0]  y_i,
  input  logic signed [35:0]  z_i,
  input  logic [32:0]         radius_i,
  input  logic [36:0]         flat_i,
  input  logic [15:0]         tol_i,
  output logic signed [32:0]  lon_o,
  output logic signed [31:0]  lat_o,
  output logic signed [35:0]  hgt_o,
  output logic                nc_o
);

  function automatic logic [63:0] q40(input logic [127:0] p);
    return (p[127:104] != 24'd0) ? {64{1'b1}} : p[103:40];
  endfunction

  logic signed [35:0] x_q, y_q, z_q;
  logic [63:0]  e2_q, dz_q, zz_q, nh_q, sn_q, nrad_q, tmp_q, dnew_q, rho_q;
  logic [127:0] rho2_q, t_q;
  logic         conv_q, done_q;
  e2g_pkg::op_t op_q;
  logic signed [32:0] lon_q;
  logic signed [31:0] lat_q;
  logic signed [35:0] hgt_q;

  logic [35:0]  magx, magy, magz;
  logic [63:0]  ax16, ay16, az16, z16, az, diff, dmag, h16, hr, pq;
  logic [47:0]  hs;
  logic [35:0]  hsat;

  logic         mul_go, sqd_go, sqd_sqrt, cor_go;
  logic [63:0]  mul_a, mul_b, sqd_d;
  logic [127:0] sqd_n, prod;
  logic signed [63:0] cor_y, cor_x;
  logic         mul_done, sqd_done, cor_done, unit_done;
  logic [63:0]  sqd_res;
  logic signed [32:0] ang;

  assign magx = x_q[35] ? 36'(-x_q) : 36'(x_q);
  assign magy = y_q[35] ? 36'(-y_q) : 36'(y_q);
  assign magz = z_q[35] ? 36'(-z_q) : 36'(z_q);
  assign ax16 = {12'd0, magx, 16'd0};
  assign ay16 = {12'd0, magy, 16'd0};
  assign az16 = {12'd0, magz, 16'd0};
  assign z16  = {{12{z_q[35]}}, z_q, 16'd0};
  assign az   = zz_q[63] ? -zz_q : zz_q;
  assign diff = dz_q - dnew_q;
  assign dmag = diff[63] ? -diff : diff;
  assign pq   = q40(prod);

  // height: round half up to mm, then saturate to 36 bits
  assign h16  = nh_q - nrad_q;
  assign hr   = h16 + 64'd32768;
  assign hs   = hr[63:16];
  assign hsat = (hs[47:35] == 13'd0 || hs[47:35] == {13{1'b1}}) ? hs[35:0] :
                (hs[47] ? 36'h8_0000_0000 : 36'h7_ffff_ffff);

  always_comb begin
    mul_go   = 1'b0;
    sqd_go   = 1'b0;
    cor_go   = 1'b0;
    sqd_sqrt = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    sqd_n    = '0;
    sqd_d    = '0;
    cor_y    = '0;
    cor_x    = '0;
    case (cmd_i.op)
      e2g_pkg::OP_E2: begin
        mul_go = 1'b1;
        mul_a  = {27'd0, flat_i};
        mul_b  = (64'd1 << 41) - {27'd0, flat_i};
      end
      e2g_pkg::OP_RX: begin
        mul_go = 1'b1;
        mul_a  = ax16;
        mul_b  = ax16;
      end
      e2g_pkg::OP_RY: begin
        mul_go = 1'b1;
        mul_a  = ay16;
        mul_b  = ay16;
      end
      e2g_pkg::OP_DZ0: begin
        mul_go = 1'b1;
        mul_a  = az16;
        mul_b  = e2_q;
      end
      e2g_pkg::OP_AZ2: begin
        mul_go = 1'b1;
        mul_a  = az;
        mul_b  = az;
      end
      e2g_pkg::OP_S2: begin
        mul_go = 1'b1;
        mul_a  = sn_q;
        mul_b  = sn_q;
      end
      e2g_pkg::OP_DEN: begin
        mul_go = 1'b1;
        mul_a  = e2_q;
        mul_b  = tmp_q;
      end
      e2g_pkg::OP_D1: begin
        mul_go = 1'b1;
        mul_a  = nrad_q;
        mul_b  = e2_q;
      end
      e2g_pkg::OP_D2: begin
        mul_go = 1'b1;
        mul_a  = tmp_q;
        mul_b  = sn_q;
      end
      e2g_pkg::OP_NH: begin
        sqd_go   = 1'b1;
        sqd_sqrt = 1'b1;
        sqd_n    = t_q;
      end
      e2g_pkg::OP_SN: begin
        sqd_go = 1'b1;
        sqd_n  = {24'd0, az, 40'd0};
        sqd_d  = nh_q;
      end
      e2g_pkg::OP_Q: begin
        sqd_go   = 1'b1;
        sqd_sqrt = 1'b1;
        sqd_n    = {24'd0, tmp_q, 40'd0};
      end
      e2g_pkg::OP_NRAD: begin
        sqd_go = 1'b1;
        sqd_n  = {39'd0, radius_i, 56'd0};
        sqd_d  = tmp_q;
      end
      e2g_pkg::OP_RHO: begin
        sqd_go   = 1'b1;
        sqd_sqrt = 1'b1;
        sqd_n    = rho2_q;
      end
      e2g_pkg::OP_LON: begin
        cor_go = 1'b1;
        cor_y  = 64'(y_q);
        cor_x  = 64'(x_q);
      end
      e2g_pkg::OP_LAT: begin
        cor_go = 1'b1;
        cor_y  = $signed(zz_q);
        cor_x  = $signed(rho_q);
      end
      default: ;
    endcase
  end

  e2g_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  e2g_sqdiv u_sqdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && sqd_go),
    .sqrt_i  (sqd_sqrt),
    .n_i     (sqd_n),
    .d_i     (sqd_d),
    .done_o  (sqd_done),
    .res_o   (sqd_res)
  );

  e2g_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start && cor_go),
    .y_i     (cor_y),
    .x_i     (cor_x),
    .done_o  (cor_done),
    .ang_o   (ang)
  );

  assign unit_done = mul_done || sqd_done || cor_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      op_q   <= e2g_pkg::OP_ZOUT;
    end else begin
      done_q <= unit_done || (cmd_i.start && !mul_go && !sqd_go && !cor_go);
      if (cmd_i.start) begin
        op_q <= cmd_i.op;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= x_i;
      y_q    <= y_i;
      z_q    <= z_i;
      conv_q <= 1'b0;
    end
    if (cmd_i.start) begin
      case (cmd_i.op)
        e2g_pkg::OP_ZOUT: begin
          lon_q  <= 33'sd0;
          lat_q  <= 32'sd0;
          hgt_q  <= $signed(36'(-{3'd0, radius_i}));
          conv_q <= 1'b1;
        end
        e2g_pkg::OP_ZZ:  zz_q <= z16 + dz_q;
        e2g_pkg::OP_CHK: begin
          conv_q <= dmag < {48'd0, tol_i};
          dz_q   <= dnew_q;
        end
        e2g_pkg::OP_HGT: hgt_q <= $signed(hsat);
        default: ;
      endcase
    end
    if (unit_done) begin
      case (op_q)
        e2g_pkg::OP_E2:   e2_q   <= pq;
        e2g_pkg::OP_RX:   rho2_q <= prod;
        e2g_pkg::OP_RY:   rho2_q <= rho2_q + prod;
        e2g_pkg::OP_DZ0:  dz_q   <= z_q[35] ? -pq : pq;
        e2g_pkg::OP_AZ2:  t_q    <= rho2_q + prod;
        e2g_pkg::OP_S2:   tmp_q  <= pq;
        e2g_pkg::OP_DEN:  tmp_q  <= e2g_pkg::Q40_ONE - pq;
        e2g_pkg::OP_D1:   tmp_q  <= pq;
        e2g_pkg::OP_D2:   dnew_q <= zz_q[63] ? -pq : pq;
        e2g_pkg::OP_NH:   nh_q   <= sqd_res;
        e2g_pkg::OP_SN: begin
          if (nh_q == 64'd0) begin
            sn_q <= 64'd0;
          end else begin
            sn_q <= (sqd_res > e2g_pkg::Q40_ONE) ? e2g_pkg::Q40_ONE : sqd_res;
          end
        end
        e2g_pkg::OP_Q:    tmp_q  <= sqd_res;
        e2g_pkg::OP_NRAD: nrad_q <= sqd_res;
        e2g_pkg::OP_RHO:  rho_q  <= sqd_res;
        e2g_pkg::OP_LON:  lon_q  <= ang;
        e2g_pkg::OP_LAT:  lat_q  <= ang[31:0];
        default: ;
      endcase
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.zero = (x_q == 36'sd0) && (y_q == 36'sd0) && (z_q == 36'sd0);
  assign stat_o.conv = conv_q;

  assign lon_o = lon_q;
  assign lat_o = lat_q;
  assign hgt_o = hgt_q;
  assign nc_o  = !conv_q;

endmodule

/* hw/rtl/e2g_ctrl.sv */
`timescale 1ns / 1ps

// sequencer: issues one datapath operation at a time and waits for done
module e2g_ctrl #(
  parameter int unsigned MAX_ITER = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  output logic           s_ready_o,
  input  logic           out_free_i,
  input  e2g_pkg::stat_t stat_i,
  output e2g_pkg::cmd_t  cmd_o
);

  localparam int unsigned CntW = $clog2(MAX_ITER);
  localparam logic [CntW-1:0] LastCnt = CntW'(MAX_ITER - 1);

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_FIRST = 5'd1;
  localparam logic [4:0] ST_RX    = 5'd2;
  localparam logic [4:0] ST_RY    = 5'd3;
  localparam logic [4:0] ST_DZ0   = 5'd4;
  localparam logic [4:0] ST_ZZ    = 5'd5;
  localparam logic [4:0] ST_AZ2   = 5'd6;
  localparam logic [4:0] ST_NH    = 5'd7;
  localparam logic [4:0] ST_SN    = 5'd8;
  localparam logic [4:0] ST_S2    = 5'd9;
  localparam logic [4:0] ST_DEN   = 5'd10;
  localparam logic [4:0] ST_Q     = 5'd11;
  localparam logic [4:0] ST_NRAD  = 5'd12;
  localparam logic [4:0] ST_D1    = 5'd13;
  localparam logic [4:0] ST_D2    = 5'd14;
  localparam logic [4:0] ST_CHK   = 5'd15;
  localparam logic [4:0] ST_RHO   = 5'd16;
  localparam logic [4:0] ST_LON   = 5'd17;
  localparam logic [4:0] ST_LAT   = 5'd18;
  localparam logic [4:0] ST_HGT   = 5'd19;
  localparam logic [4:0] ST_EMIT  = 5'd20;

  logic [4:0]      state_q, nxt;
  logic            issued_q, final_q, work;
  logic [CntW-1:0] cnt_q;
  e2g_pkg::op_t    op;

  always_comb begin
    op   = e2g_pkg::OP_E2;
    nxt  = ST_IDLE;
    work = 1'b1;
    case (state_q)
      ST_IDLE:  work = 1'b0;
      ST_FIRST: begin
        op  = stat_i.zero ? e2g_pkg::OP_ZOUT : e2g_pkg::OP_E2;
        nxt = stat_i.zero ? ST_EMIT : ST_RX;
      end
      ST_RX:   begin op = e2g_pkg::OP_RX;   nxt = ST_RY;  end
      ST_RY:   begin op = e2g_pkg::OP_RY;   nxt = ST_DZ0; end
      ST_DZ0:  begin op = e2g_pkg::OP_DZ0;  nxt = ST_ZZ;  end
      ST_ZZ:   begin op = e2g_pkg::OP_ZZ;   nxt = ST_AZ2; end
      ST_AZ2:  begin op = e2g_pkg::OP_AZ2;  nxt = ST_NH;  end
      ST_NH:   begin op = e2g_pkg::OP_NH;   nxt = ST_SN;  end
      ST_SN:   begin op = e2g_pkg::OP_SN;   nxt = ST_S2;  end
      ST_S2:   begin op = e2g_pkg::OP_S2;   nxt = ST_DEN; end
      ST_DEN:  begin op = e2g_pkg::OP_DEN;  nxt = ST_Q;   end
      ST_Q:    begin op = e2g_pkg::OP_Q;    nxt = ST_NRAD; end
      ST_NRAD: begin
        op  = e2g_pkg::OP_NRAD;
        nxt = final_q ? ST_RHO : ST_D1;
      end
      ST_D1:   begin op = e2g_pkg::OP_D1;   nxt = ST_D2;  end
      ST_D2:   begin op = e2g_pkg::OP_D2;   nxt = ST_CHK; end
      ST_CHK:  begin op = e2g_pkg::OP_CHK;  nxt = ST_ZZ;  end
      ST_RHO:  begin op = e2g_pkg::OP_RHO;  nxt = ST_LON; end
      ST_LON:  begin op = e2g_pkg::OP_LON;  nxt = ST_LAT; end
      ST_LAT:  begin op = e2g_pkg::OP_LAT;  nxt = ST_HGT; end
      ST_HGT:  begin op = e2g_pkg::OP_HGT;  nxt = ST_EMIT; end
      ST_EMIT: work = 1'b0;
      default: work = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      issued_q <= 1'b0;
      final_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (s_valid_i) begin
            state_q  <= ST_FIRST;
            issued_q <= 1'b0;
            final_q  <= 1'b0;
            cnt_q    <= '0;
          end
        end
        ST_EMIT: begin
          if (out_free_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          if (!issued_q) begin
            issued_q <= 1'b1;
          end else if (stat_i.done) begin
            issued_q <= 1'b0;
            state_q  <= nxt;
            if (state_q == ST_CHK) begin
              cnt_q <= cnt_q + CntW'(1);
              if (stat_i.conv || cnt_q == LastCnt) begin
                final_q <= 1'b1;
              end
            end
          end
        end
      endcase
    end
  end

  assign s_ready_o   = state_q == ST_IDLE;
  assign cmd_o.start = work && !issued_q;
  assign cmd_o.load  = (state_q == ST_IDLE) && s_valid_i;
  assign cmd_o.emit  = (state_q == ST_EMIT) && out_free_i;
  assign cmd_o.op    = op;

endmodule

/* hw/rtl/ecef_to_geodetic.sv */
`timescale 1ns / 1ps

// channel   direction  width  contents
// s_axis    in         112    x_mm, y_mm, z_mm position
// m_axis    out        104+1  longitude, latitude, height_mm; tuser not_converged
// cfg       in         2+37   register index and write data
//
// one position at a time; a conversion runs k correction passes (1 to MAX_ITER),
// each using the 64-step shared square-root/divide unit; small coordinates add
// cordic normalisation steps; a zero vector skips the passes and goes straight
// to the output
// reset clears the sequencer and output valid and loads the WGS-84 registers
// a new position is taken while a finished result still waits in the output
// register; m_axis_tready low only stalls the final hand-off
module ecef_to_geodetic #(
  parameter int unsigned MAX_ITER = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  // x_mm [35:0], y_mm [71:36], z_mm [107:72], zero fill above
  input  logic [111:0]  s_axis_tdata,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // longitude [32:0], latitude [64:33], height_mm [100:65], zero fill above
  output logic [103:0]  m_axis_tdata,
  // not_converged [0]
  output logic          m_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_addr_i,
  input  logic [36:0]   cfg_data_i
);

  // ellipsoid and tolerance registers
  logic [32:0] radius_q;
  logic [36:0] flat_q;
  logic [15:0] tol_q;

  // output holding register
  logic [103:0] tdata_q;
  logic         tuser_q, tvalid_q, out_free;

  e2g_pkg::cmd_t  cmd;
  e2g_pkg::stat_t stat;

  logic signed [32:0] lon;
  logic signed [31:0] lat;
  logic signed [35:0] hgt;
  logic               nc;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !tvalid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= e2g_pkg::RADIUS_RST;
      flat_q   <= e2g_pkg::FLAT_RST;
      tol_q    <= e2g_pkg::TOL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        e2g_pkg::REG_RADIUS: radius_q <= cfg_data_i[32:0];
        e2g_pkg::REG_FLAT:   flat_q   <= cfg_data_i;
        e2g_pkg::REG_TOL:    tol_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  e2g_ctrl #(
    .MAX_ITER (MAX_ITER)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  e2g_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .x_i      ($signed(s_axis_tdata[35:0])),
    .y_i      ($signed(s_axis_tdata[71:36])),
    .z_i      ($signed(s_axis_tdata[107:72])),
    .radius_i (radius_q),
    .flat_i   (flat_q),
    .tol_i    (tol_q),
    .lon_o    (lon),
    .lat_o    (lat),
    .hgt_o    (hgt),
    .nc_o     (nc)
  );

  // result transfer register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (cmd.emit) begin
      tvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      tdata_q <= {3'd0, hgt, lat, lon};
      tuser_q <= nc;
    end
  end

  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;
  assign m_axis_tvalid = tvalid_q;

  // a result is only handed over when the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!tvalid_q || m_axis_tready))
    else $error("result emitted over a pending transfer");

  // no datapath operation is issued while a new position can be taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.start && s_axis_tready))
    else $error("operation issued while idle");

  // an accepted position closes the input until its result is out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input reopened right after a transfer");

endmodule
